### hdl/mptw_pkg.sv
// Shared types and constants for the multilevel page table walker.
package mptw_pkg;

   // Default geometry of the table store and the walk
   localparam int FRAME_COUNT_DEF = 64;
   localparam int LEVELS_DEF      = 5;
   localparam int INDEX_BITS_DEF  = 9;

   // Fixed field widths
   localparam int PPN_W        = 52;
   localparam int ENTRY_W      = PPN_W + 1;
   localparam int ACTION_W     = 2;
   localparam int STATUS_W     = 2;
   localparam int ROOT_W       = 6;
   localparam int FIRST_FREE_W = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 7;

   // Entry layout: valid bit above the frame number
   localparam int VALID_POS = PPN_W;

   // Action codes; the unused code walks as a query
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MAP   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_UNMAP = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_FRAME       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_FREE_FRAME = 2'd1;

   // Reset value of the allocator
   localparam int FIRST_FREE_RST = 1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NO_MAP    = 2'd1,
      ST_NO_FRAMES = 2'd2
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADDR,
      S_CHECK,
      S_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       clear_step;
      logic       start;
      logic       rd;
      logic       follow;
      logic       wr_table;
      logic       wr_leaf_map;
      logic       wr_leaf_unmap;
      logic       load_rsp;
      logic       rsp_found;
      status_type rsp_status;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic frame_ok;
      logic at_leaf;
      logic entry_valid;
      logic alloc_empty;
      logic is_map;
      logic is_unmap;
   } sts_type;

endpackage

### hdl/multilevel_page_table_walker_top.sv
// Top level of the multilevel page table walker: controller, datapath and checks.
// Each transaction is a query, map or unmap of one virtual page number, walked
// one level per step from the configured root frame through a private store of
// FRAME_COUNT frames of 2^INDEX_BITS entries held in a single-port-write,
// registered-read memory. Each level has an address step, then a check of the
// registered read data, except the leaf of a map, which is written in its
// address step. The next request is taken the cycle after the result is
// loaded, so a request is not taken until the previous walk is through. A walk
// that stops early ends sooner than one that reaches the leaf. A new request is
// taken after the previous result is parked in the output register, even while
// that result is still stalled. After reset the store is cleared one entry per
// cycle, and requests stall until the clearing pass ends; configuration writes
// are always taken. Map allocates intermediate tables from a counting allocator
// and stops with out-of-frames status when it runs dry.
module multilevel_page_table_walker_top
   import mptw_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int LEVELS      = LEVELS_DEF,
   parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [ACTION_W-1:0]          req_action,
   input  logic [LEVELS*INDEX_BITS-1:0] req_vpn,
   input  logic [PPN_W-1:0]             req_ppn,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [PPN_W-1:0]             rsp_ppn_out,
   output logic [STATUS_W-1:0]          rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Configuration writes never wait
   assign csr_ready = 1'b1;

   mptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mptw_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .LEVELS      (LEVELS),
      .INDEX_BITS  (INDEX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_action  (req_action),
      .req_vpn     (req_vpn),
      .req_ppn     (req_ppn),
      .rsp_ppn_out (rsp_ppn_out),
      .rsp_status  (rsp_status),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // No transaction enters while the store is being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> req_stall)
      else $error("request accepted during clearing pass");

   // At most one memory write per cycle
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.wr_table, cmd.wr_leaf_map, cmd.wr_leaf_unmap}))
      else $error("conflicting table writes");

   // Allocate a table only while frames remain
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_table |-> !sts.alloc_empty)
      else $error("table allocated from an empty allocator");

   // Never overwrite a result still held by a stalled receiver
   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

endmodule

### hdl/mptw_datapath.sv
// Datapath of the walker: table store, walk registers, allocator, config and result registers.
module mptw_datapath
   import mptw_pkg::*;
#(
   parameter int FRAME_COUNT = FRAME_COUNT_DEF,
   parameter int LEVELS      = LEVELS_DEF,
   parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic [LEVELS*INDEX_BITS-1:0] req_vpn,
   input  logic [PPN_W-1:0]          req_ppn,
   output logic [PPN_W-1:0]          rsp_ppn_out,
   output logic [STATUS_W-1:0]       rsp_status,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ENTRIES  = 1 << INDEX_BITS;
   localparam int DEPTH    = FRAME_COUNT * ENTRIES;
   localparam int FRAME_W  = $clog2(FRAME_COUNT);
   localparam int ADDR_W   = FRAME_W + INDEX_BITS;
   localparam int VPN_W    = LEVELS * INDEX_BITS;
   localparam int LV_W     = $clog2(LEVELS + 1);
   localparam int CNT_W    = $clog2(FRAME_COUNT + 1);
   localparam int ALLOC_W  = (CNT_W > FIRST_FREE_W) ? CNT_W : FIRST_FREE_W;

   // Table store
   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [ADDR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [VPN_W-1:0]    vpn_ff, vpn_in;
   logic [PPN_W-1:0]    ppn_ff, ppn_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic                frame_ok_ff, frame_ok_in;
   logic [LV_W-1:0]     lv_ff, lv_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [ALLOC_W-1:0]  alloc_ff, alloc_in;
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [PPN_W-1:0]    rsp_ppn_out_ff, rsp_ppn_out_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [INDEX_BITS-1:0] idx;
   logic [ADDR_W-1:0]     addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [PPN_W-1:0]      frame_cand;
   logic                  load_frame;

   // Current level index is the top slice of the shifting vpn
   assign idx  = vpn_ff[VPN_W-1 -: INDEX_BITS];
   assign addr = {frame_ff, idx};

   // Select the single memory write of this cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr;
      wr_data = '0;
      priority if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
      end else if (cmd.wr_table) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, PPN_W'(alloc_ff)};
      end else if (cmd.wr_leaf_map) begin
         wr_en   = 1'b1;
         wr_data = {1'b1, ppn_ff};
      end else if (cmd.wr_leaf_unmap) begin
         wr_en   = 1'b1;
         wr_data = {1'b0, rd_data_ff[PPN_W-1:0]};
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered table read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   // Pick the next frame and check that it lies inside the store
   always_comb begin
      load_frame = cmd.start | cmd.follow | cmd.wr_table;
      priority if (cmd.start) begin
         frame_cand = PPN_W'(root_ff);
      end else if (cmd.wr_table) begin
         frame_cand = PPN_W'(alloc_ff);
      end else begin
         frame_cand = rd_data_ff[PPN_W-1:0];
      end
   end

   // Walk registers: level, vpn shift, frame, request fields and the clear counter
   always_comb begin
      clr_cnt_in  = cmd.clear_step ? clr_cnt_ff + ADDR_W'(1) : clr_cnt_ff;
      vpn_in      = vpn_ff;
      ppn_in      = ppn_ff;
      action_in   = action_ff;
      lv_in       = lv_ff;
      frame_in    = load_frame ? FRAME_W'(frame_cand) : frame_ff;
      frame_ok_in = load_frame ? (frame_cand < PPN_W'(FRAME_COUNT)) : frame_ok_ff;
      if (cmd.start) begin
         vpn_in    = req_vpn;
         ppn_in    = req_ppn;
         action_in = req_action;
         lv_in     = '0;
      end else if (cmd.follow || cmd.wr_table) begin
         vpn_in = vpn_ff << INDEX_BITS;
         lv_in  = lv_ff + LV_W'(1);
      end
   end

   // Configuration registers and the allocator
   always_comb begin
      root_in  = root_ff;
      alloc_in = alloc_ff;
      if (cmd.wr_table) begin
         alloc_in = alloc_ff + ALLOC_W'(1);
      end
      if (csr_write) begin
         if (csr_index == CSR_ROOT_FRAME) begin
            root_in = csr_wdata[ROOT_W-1:0];
         end
         if (csr_index == CSR_FIRST_FREE_FRAME) begin
            alloc_in = ALLOC_W'(csr_wdata[FIRST_FREE_W-1:0]);
         end
      end
   end

   // Result register
   always_comb begin
      rsp_ppn_out_in = rsp_ppn_out_ff;
      rsp_status_in  = rsp_status_ff;
      if (cmd.load_rsp) begin
         rsp_ppn_out_in = cmd.rsp_found ? rd_data_ff[PPN_W-1:0] : '0;
         rsp_status_in  = cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         root_ff    <= '0;
         alloc_ff   <= ALLOC_W'(FIRST_FREE_RST);
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         root_ff    <= root_in;
         alloc_ff   <= alloc_in;
      end
   end

   always_ff @(posedge clock) begin
      vpn_ff         <= vpn_in;
      ppn_ff         <= ppn_in;
      action_ff      <= action_in;
      lv_ff          <= lv_in;
      frame_ff       <= frame_in;
      frame_ok_ff    <= frame_ok_in;
      rsp_ppn_out_ff <= rsp_ppn_out_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Status toward the controller
   assign sts.clear_last  = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign sts.frame_ok    = frame_ok_ff;
   assign sts.at_leaf     = (lv_ff == LV_W'(LEVELS - 1));
   assign sts.entry_valid = rd_data_ff[VALID_POS];
   assign sts.alloc_empty = (alloc_ff >= ALLOC_W'(FRAME_COUNT));
   assign sts.is_map      = (action_ff == ACT_MAP);
   assign sts.is_unmap    = (action_ff == ACT_UNMAP);

   assign rsp_ppn_out = rsp_ppn_out_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

### hdl/mptw_ctrl.sv
// Controller state machine of the walker: clearing pass, level walk and result handoff.
module mptw_ctrl
   import mptw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type res_status_ff, res_status_in;
   logic       res_found_ff, res_found_in;
   logic       rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_ADDR;
         end
         S_ADDR: begin
            if (!sts.frame_ok || (sts.at_leaf && sts.is_map)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.at_leaf && (sts.entry_valid || (sts.is_map && !sts.alloc_empty))) begin
               state_in = S_ADDR;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Commands and result bookkeeping
   always_comb begin
      cmd           = '0;
      cmd.rsp_found = res_found_ff;
      cmd.rsp_status = res_status_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.start    = req_valid;
            res_found_in = 1'b0;
         end
         S_ADDR: begin
            if (!sts.frame_ok) begin
               res_status_in = sts.is_map ? ST_NO_FRAMES : ST_NO_MAP;
            end else if (sts.at_leaf && sts.is_map) begin
               cmd.wr_leaf_map = 1'b1;
               res_status_in   = ST_DONE;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_CHECK: begin
            if (!sts.at_leaf) begin
               if (sts.entry_valid) begin
                  cmd.follow = 1'b1;
               end else if (sts.is_map) begin
                  if (sts.alloc_empty) begin
                     res_status_in = ST_NO_FRAMES;
                  end else begin
                     cmd.wr_table = 1'b1;
                  end
               end else begin
                  res_status_in = ST_NO_MAP;
               end
            end else if (sts.entry_valid) begin
               cmd.wr_leaf_unmap = sts.is_unmap;
               res_status_in     = ST_DONE;
               res_found_in      = !sts.is_unmap;
            end else begin
               res_status_in = ST_NO_MAP;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= ST_DONE;
         res_found_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
         res_found_ff  <= res_found_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
